[hw/rtl/cordic_sine_cosine_unit_macros.svh]
// ----------------------------------------------------------------------------
// cordic sine/cosine unit assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINE_COSINE_UNIT_MACROS_SVH
`define CORDIC_SINE_COSINE_UNIT_MACROS_SVH

// same-cycle implication
`define CSC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cordic sine/cosine unit: same-cycle check failed");

// next-cycle implication
`define CSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cordic sine/cosine unit: next-cycle check failed");

`endif

[hw/rtl/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg
// Types and constants shared by the cordic sine/cosine pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int ANGLE_W  = 16;
	localparam int RESULT_W = 17;
	// internal datapath width, headroom over the q15 results and the residual angle
	localparam int DATA_W   = 18;
	localparam int TABLE_LEN = 15;

	localparam logic signed [DATA_W-1:0] START_COS    = 18'sd19898;
	localparam logic signed [DATA_W-1:0] QUARTER_TURN = 18'sd16384;
	localparam logic signed [DATA_W-1:0] HALF_TURN    = 18'sd32768;

	// atan(2^-i) in angle units, 65536 per turn
	localparam logic signed [DATA_W-1:0] ARC_TABLE [TABLE_LEN] = '{
		18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651,
		18'sd326,  18'sd163,  18'sd81,   18'sd41,   18'sd20,
		18'sd10,   18'sd5,    18'sd3,    18'sd1,    18'sd1
	};

	typedef logic signed [DATA_W-1:0] csc_data_t;

	typedef struct packed {
		csc_data_t x;     // cosine accumulator
		csc_data_t y;     // sine accumulator
		csc_data_t z;     // residual angle
		logic      neg;   // heading was folded, negate at the end
	} csc_vec_t;

endpackage

[hw/rtl/csc_fold.sv]
// ----------------------------------------------------------------------------
// csc_fold
// First pipeline stage: folds the heading into the right half plane and
// loads the prescaled start vector.
// ----------------------------------------------------------------------------
module csc_fold import csc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_in,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      valid_s1,
	output csc_vec_t                  vec_s1
);

	csc_data_t angle_ext;
	csc_vec_t  vec_d;

	assign angle_ext = csc_data_t'(angle);

	always_comb begin
		vec_d.x   = START_COS;
		vec_d.y   = '0;
		vec_d.z   = angle_ext;
		vec_d.neg = 1'b0;
		// exactly a quarter turn stays unfolded
		if (angle_ext > QUARTER_TURN) begin
			vec_d.z   = angle_ext - HALF_TURN;
			vec_d.neg = 1'b1;
		end else if (angle_ext < -QUARTER_TURN) begin
			vec_d.z   = angle_ext + HALF_TURN;
			vec_d.neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_d;
		end
	end

endmodule

[hw/rtl/csc_stage.sv]
// ----------------------------------------------------------------------------
// csc_stage
// One registered cordic micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module csc_stage import csc_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     valid_in,
	input  csc_vec_t vec_in,
	output logic     valid_s1,
	output csc_vec_t vec_s1
);

	csc_data_t dx;
	csc_data_t dy;
	csc_vec_t  vec_d;

	assign dx = vec_in.x >>> SHIFT;
	assign dy = vec_in.y >>> SHIFT;

	always_comb begin
		vec_d.neg = vec_in.neg;
		// zero residual rotates counterclockwise
		if (!vec_in.z[DATA_W-1]) begin
			vec_d.x = vec_in.x - dy;
			vec_d.y = vec_in.y + dx;
			vec_d.z = vec_in.z - ARC_TABLE[SHIFT];
		end else begin
			vec_d.x = vec_in.x + dy;
			vec_d.y = vec_in.y - dx;
			vec_d.z = vec_in.z + ARC_TABLE[SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_d;
		end
	end

endmodule

[hw/rtl/cordic_sine_cosine_unit.sv]
// ----------------------------------------------------------------------------
// cordic_sine_cosine_unit
// Pipelined rotation-mode cordic giving q15 sine and cosine of a heading.
// ----------------------------------------------------------------------------
// Input channel: heading_angle, 65536 per turn, signed, with in_valid and
// in_stall. Output channel: sine_q15 and cosine_q15, signed 17 bit, with
// out_valid and out_stall. A beat moves when valid is high and stall is low.
// The pipeline is one fold stage, one register stage per micro-rotation,
// and the output register that applies the half-turn sign.
// Throughput is one beat per cycle unless the output stalls; a new heading
// enters every such cycle while earlier ones are still in the pipeline.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised; no beat is dropped or repeated. Bubbles move forward
// freely while the output is empty or being taken.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_unit import csc_pkg::*; #(
	parameter int ITERATIONS = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [ANGLE_W-1:0]  heading_angle,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [RESULT_W-1:0] sine_q15,
	output logic signed [RESULT_W-1:0] cosine_q15
);

	localparam int STAGES = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

	logic      en;
	logic      stage_valid [STAGES+1];
	csc_vec_t  stage_vec   [STAGES+1];
	csc_vec_t  last_vec;
	csc_data_t sine_d;
	csc_data_t cosine_d;
	logic      out_valid_q;

	// pipeline moves unless a finished result is held back
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	csc_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (in_valid),
		.angle    (heading_angle),
		.valid_s1 (stage_valid[0]),
		.vec_s1   (stage_vec[0])
	);

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		csc_stage #(
			.SHIFT (i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (stage_valid[i]),
			.vec_in   (stage_vec[i]),
			.valid_s1 (stage_valid[i+1]),
			.vec_s1   (stage_vec[i+1])
		);
	end

	assign last_vec = stage_vec[STAGES];
	assign sine_d   = last_vec.neg ? -last_vec.y : last_vec.y;
	assign cosine_d = last_vec.neg ? -last_vec.x : last_vec.x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= stage_valid[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_q15   <= sine_d[RESULT_W-1:0];
			cosine_q15 <= cosine_d[RESULT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/csc_checker.sv]
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks of the cordic sine/cosine unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "cordic_sine_cosine_unit_macros.svh"

module csc_checker import csc_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic signed [ANGLE_W-1:0]  heading_angle,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [RESULT_W-1:0] sine_q15,
	input logic signed [RESULT_W-1:0] cosine_q15
);

	logic sine_near_unit;
	logic cosine_near_unit;

	assign sine_near_unit   = sine_q15 <= 17'sd33000 && sine_q15 >= -17'sd33000;
	assign cosine_near_unit = cosine_q15 <= 17'sd33000 && cosine_q15 >= -17'sd33000;

	// a held heading beat keeps its payload
	`CSC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(heading_angle))

	// a held result beat keeps its payload
	`CSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({sine_q15, cosine_q15}))

	// input backpressure only comes from a stalled result
	`CSC_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)

	// a result that is taken leaves the input open
	`CSC_ASSERT_SAME(a_stall_free, out_valid && !out_stall, !in_stall)

	// each result component stays within about full scale (+/-33000)
	`CSC_ASSERT_SAME(a_range, out_valid, sine_near_unit && cosine_near_unit)

endmodule

bind cordic_sine_cosine_unit csc_checker u_csc_checker (.*);

[tb/cordic_sine_cosine_unit_tb.sv]
// ----------------------------------------------------------------------------
// cordic_sine_cosine_unit_tb
// Self-checking bench for the pipelined cordic sine/cosine unit. A directed
// table of headings covers the quarter-turn fold boundaries, the wrap points
// and the residual angle landing on zero. About six hundred random headings
// follow, most uniform and the rest clustered on the fold and wrap edges and
// around zero. Each accepted heading is run through a local shift-and-add
// model and queued, and every result beat is compared against the oldest
// entry. The sender idles between random bursts and the receiver stalls on
// a changing pattern of its own.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_unit_tb;
	import csc_pkg::*;

	localparam int ITERATIONS = 15;
	localparam int LATENCY    = ITERATIONS + 2;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_HEADINGS = 600;
	localparam int PRINT_LIMIT = 40;

	// arctangent steps, 65536 per turn
	localparam int ATAN_STEP [15] = '{
		8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
	};

	localparam logic signed [ANGLE_W-1:0] DIRECTED_HEADINGS [22] = '{
		16'sd0, 16'sd1, -16'sd1, 16'sd8192, -16'sd8192,
		16'sd16383, 16'sd16384, 16'sd16385,
		-16'sd16383, -16'sd16384, -16'sd16385,
		16'sd24576, -16'sd24576, 16'sd32767, 16'sh8000, -16'sd32767,
		16'sd4096, -16'sd4096, 16'sh5555, 16'shAAAA, 16'sd12345, -16'sd12345
	};

	typedef struct packed {
		logic signed [RESULT_W-1:0] sine;
		logic signed [RESULT_W-1:0] cosine;
	} sincos_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [ANGLE_W-1:0]   heading_angle = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [RESULT_W-1:0]  sine_q15;
	logic signed [RESULT_W-1:0]  cosine_q15;

	sincos_t pending_sincos [$];
	int      mismatches = 0;
	int      headings_sent = 0;
	int      headings_folded = 0;
	int      results_seen = 0;
	int      stall_cycles = 0;
	int      burst_left = 0;

	cordic_sine_cosine_unit #(
		.ITERATIONS(ITERATIONS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.heading_angle(heading_angle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sine_q15(sine_q15),
		.cosine_q15(cosine_q15)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic sincos_t cordic_sincos(input logic signed [ANGLE_W-1:0] heading);
		int      z;
		int      x;
		int      y;
		int      dx;
		int      dy;
		int      steps;
		bit      flip;
		sincos_t r;
		z = heading;
		x = int'(START_COS);
		y = 0;
		flip = 1'b0;
		if (z > int'(QUARTER_TURN)) begin
			z = z - int'(HALF_TURN);
			flip = 1'b1;
		end else if (z < -int'(QUARTER_TURN)) begin
			z = z + int'(HALF_TURN);
			flip = 1'b1;
		end
		steps = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
		for (int i = 0; i < steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			// zero residual counts as positive, rotate counterclockwise
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_STEP[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_STEP[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		r.sine = y[RESULT_W-1:0];
		r.cosine = x[RESULT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// one heading beat, with random gaps between bursts
	task automatic send_heading(input logic signed [ANGLE_W-1:0] heading);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			heading_angle <= ANGLE_W'($urandom_range(0, 65535));
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
				: $urandom_range(1, 10);
		end
		heading_angle <= heading;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_sincos.push_back(cordic_sincos(heading));
		headings_sent++;
		if (heading > 16384 || heading < -16384)
			headings_folded++;
		burst_left--;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_sincos.size() != 0) @(posedge clk);
	endtask

	// receiver stall pattern with a randomly chosen, changing mode
	int unsigned rx_cycle = 0;
	int unsigned rx_mode = 0;
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle[5:0] == 6'd0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (rx_cycle[3:2] == 2'b11);
		endcase
	end

	// result checker
	always @(posedge clk) begin
		sincos_t want;
		if (arst_n && out_valid) begin
			if (out_stall) begin
				stall_cycles++;
			end else begin
				results_seen++;
				if (pending_sincos.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat sin=%0d cos=%0d",
						sine_q15, cosine_q15));
				end else begin
					want = pending_sincos.pop_front();
					if (sine_q15 !== want.sine)
						report_mismatch($sformatf("sine got %0d want %0d",
							sine_q15, want.sine));
					if (cosine_q15 !== want.cosine)
						report_mismatch($sformatf("cosine got %0d want %0d",
							cosine_q15, want.cosine));
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("cordic_sine_cosine_unit_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int                        pick;
		logic signed [ANGLE_W-1:0] heading;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_HEADINGS[i])
			send_heading(DIRECTED_HEADINGS[i]);
		drain_pipeline();

		for (int n = 0; n < RANDOM_HEADINGS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				heading = ANGLE_W'($urandom_range(0, 65535));
			else if (pick < 80)
				heading = ANGLE_W'((($urandom_range(0, 1) == 0) ? 16384 : -16384)
					+ int'($urandom_range(0, 16)) - 8);
			else if (pick < 90)
				heading = ANGLE_W'(32768 + int'($urandom_range(0, 16)) - 8);
			else
				heading = ANGLE_W'(int'($urandom_range(0, 512)) - 256);
			send_heading(heading);
			if (n == RANDOM_HEADINGS / 2)
				drain_pipeline();
		end
		drain_pipeline();
		repeat (LATENCY + 4) @(posedge clk);

		$display("covered %0d headings (%0d folded), %0d results, %0d stalled result cycles",
			headings_sent, headings_folded, results_seen, stall_cycles);
		if (mismatches == 0)
			$display("cordic_sine_cosine_unit_tb: done, clean");
		else
			$display("cordic_sine_cosine_unit_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/csc_pkg.sv
hw/rtl/csc_fold.sv
hw/rtl/csc_stage.sv
hw/rtl/cordic_sine_cosine_unit.sv
hw/rtl/csc_checker.sv
tb/cordic_sine_cosine_unit_tb.sv
